/* rtl/clm_pkg.sv */
// Shared types and constants for the circular list manager.
// Used by the controller, the datapath and the top level. No dependencies.
package clm_pkg;

  // Store geometry
  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Item field widths
  localparam int CMD_W  = 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 16;
  localparam int ST_W   = 2;
  localparam int LEN_W  = 9;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INS_FRONT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INS_BACK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE    = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [ST_W-1:0] ST_BOUNDS = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_GRAB_READ,
    OP_GRAB_FREE,
    OP_GRAB_FRESH,
    OP_LINK_ONLY,
    OP_LINK_NEW,
    OP_LINK_TAIL,
    OP_DEL_ONLY,
    OP_DEL_HEAD_READ,
    OP_DEL_HEAD,
    OP_WALK_START,
    OP_WALK_STEP,
    OP_WALK_END,
    OP_UNLINK,
    OP_DROP,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [ST_W-1:0] status;
  } dp_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             free_avail;
    logic             fresh_avail;
    logic             count_zero;
    logic             count_one;
    logic             pos_zero;
    logic             pos_over;
    logic             pos_one;
    logic             walk_more;
  } dp_sts_t;

endpackage

/* rtl/clm_datapath.sv */
// Datapath of the circular list manager: value and link stores, list and
// free-list pointers, walk counter and result register. Depends on clm_pkg.
module clm_datapath import clm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_ctl_t                  ctl,
  output dp_sts_t                  sts,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic [POS_W-1:0]         in_position,
  output logic [ST_W-1:0]          status,
  output logic [LEN_W-1:0]         length,
  output logic signed [DATA_W-1:0] first_value,
  output logic signed [DATA_W-1:0] last_value
);

  // Stores
  logic [DATA_W-1:0] value_mem [CAPACITY];
  logic [IDX_W-1:0]  link_mem  [CAPACITY];

  // List state
  logic [IDX_W-1:0] first_idx;
  logic [IDX_W-1:0] last_idx;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] free_head;
  logic [CNT_W-1:0] free_count;
  logic [CNT_W-1:0] fresh_next;

  // Working registers for one item
  logic [CMD_W-1:0]  cmd_r;
  logic [DATA_W-1:0] value_r;
  logic [POS_W-1:0]  pos_r;
  logic [IDX_W-1:0]  slot;
  logic [IDX_W-1:0]  prev;
  logic [IDX_W-1:0]  victim;
  logic [CNT_W-1:0]  walk_cnt;

  // Registered read data
  logic [IDX_W-1:0]  link_rd;
  logic [DATA_W-1:0] first_rd;
  logic [DATA_W-1:0] last_rd;

  // Store access controls
  logic [IDX_W-1:0] link_raddr;
  logic             link_we;
  logic [IDX_W-1:0] link_waddr;
  logic [IDX_W-1:0] link_wdata;
  logic             value_we;

  // Status towards the controller
  assign sts.cmd         = cmd_r;
  assign sts.free_avail  = (free_count != '0);
  assign sts.fresh_avail = (fresh_next < CNT_W'(CAPACITY));
  assign sts.count_zero  = (count == '0);
  assign sts.count_one   = (count == CNT_W'(1));
  assign sts.pos_zero    = (pos_r == '0);
  assign sts.pos_over    = (32'(pos_r) > 32'(count));
  assign sts.pos_one     = (pos_r == POS_W'(1));
  assign sts.walk_more   = (32'(walk_cnt) < 32'(pos_r));

  // Pick the link read address
  always_comb begin
    unique case (ctl.op)
      OP_GRAB_READ:                 link_raddr = free_head;
      OP_WALK_STEP, OP_WALK_END:    link_raddr = link_rd;
      default:                      link_raddr = first_idx;
    endcase
  end

  // Pick the link write
  always_comb begin
    link_we    = 1'b1;
    link_waddr = slot;
    link_wdata = slot;
    value_we   = 1'b0;
    unique case (ctl.op)
      OP_LINK_ONLY: begin
        value_we = 1'b1;
      end
      OP_LINK_NEW: begin
        value_we   = 1'b1;
        link_wdata = first_idx;
      end
      OP_LINK_TAIL: begin
        link_waddr = last_idx;
      end
      OP_DEL_HEAD: begin
        link_waddr = last_idx;
        link_wdata = link_rd;
      end
      OP_UNLINK: begin
        link_waddr = prev;
        link_wdata = link_rd;
      end
      OP_DROP: begin
        link_waddr = victim;
        link_wdata = free_head;
      end
      default: begin
        link_we = 1'b0;
      end
    endcase
  end

  // Store ports: one write and one read on links, one write and two reads on values
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (value_we) begin
      value_mem[slot] <= value_r;
    end
    first_rd <= value_mem[first_idx];
    last_rd  <= value_mem[last_idx];
  end

  // List and free-list pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_idx  <= '0;
      last_idx   <= '0;
      count      <= '0;
      free_head  <= '0;
      free_count <= '0;
      fresh_next <= '0;
    end else begin
      unique case (ctl.op)
        OP_GRAB_FREE: begin
          free_head  <= link_rd;
          free_count <= free_count - CNT_W'(1);
        end
        OP_GRAB_FRESH: begin
          fresh_next <= fresh_next + CNT_W'(1);
        end
        OP_LINK_ONLY: begin
          first_idx <= slot;
          last_idx  <= slot;
          count     <= count + CNT_W'(1);
        end
        OP_LINK_TAIL: begin
          if (cmd_r == CMD_INS_BACK) begin
            last_idx <= slot;
          end else begin
            first_idx <= slot;
          end
          count <= count + CNT_W'(1);
        end
        OP_DEL_ONLY: begin
          first_idx <= '0;
          last_idx  <= '0;
          count     <= count - CNT_W'(1);
        end
        OP_DEL_HEAD: begin
          first_idx <= link_rd;
          count     <= count - CNT_W'(1);
        end
        OP_UNLINK: begin
          if (victim == last_idx) begin
            last_idx <= prev;
          end
          count <= count - CNT_W'(1);
        end
        OP_DROP: begin
          free_head  <= victim;
          free_count <= free_count + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers for the item in flight
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        cmd_r   <= in_cmd;
        value_r <= in_value;
        pos_r   <= in_position;
      end
      OP_GRAB_FREE: begin
        slot <= free_head;
      end
      OP_GRAB_FRESH: begin
        slot <= fresh_next[IDX_W-1:0];
      end
      OP_DEL_ONLY, OP_DEL_HEAD_READ: begin
        victim <= first_idx;
      end
      OP_WALK_START: begin
        prev     <= first_idx;
        walk_cnt <= CNT_W'(2);
      end
      OP_WALK_STEP: begin
        prev     <= link_rd;
        walk_cnt <= walk_cnt + CNT_W'(1);
      end
      OP_WALK_END: begin
        victim <= link_rd;
      end
      default: begin
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.op == OP_RESULT) begin
      status <= ctl.status;
      length <= LEN_W'(count);
      if (count == '0) begin
        first_value <= '0;
        last_value  <= '0;
      end else begin
        first_value <= first_rd;
        last_value  <= last_rd;
      end
    end
  end

endmodule

/* rtl/clm_controller.sv */
// Controller of the circular list manager: sequences the datapath through
// each command and runs the input and result handshakes. Depends on clm_pkg.
module clm_controller import clm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_ctl_t ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_GRAB_FREE,
    S_LINK,
    S_TAIL,
    S_DEL_HEAD,
    S_WALK,
    S_UNLINK,
    S_DROP,
    S_FIN,
    S_OUT
  } state_t;

  state_t          state;
  state_t          state_next;
  logic [ST_W-1:0] status_r;
  logic [ST_W-1:0] status_next;
  logic            load;

  assign in_ready = (state == S_IDLE);
  assign load     = (state == S_OUT) && (!out_valid || out_ready);

  // Next state and datapath operation
  always_comb begin
    state_next  = state;
    status_next = status_r;
    ctl.op      = OP_NONE;
    ctl.status  = status_r;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op     = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        status_next = ST_OK;
        state_next  = S_FIN;
        unique case (sts.cmd) inside
          CMD_INS_FRONT, CMD_INS_BACK: begin
            if (sts.free_avail) begin
              ctl.op     = OP_GRAB_READ;
              state_next = S_GRAB_FREE;
            end else if (sts.fresh_avail) begin
              ctl.op     = OP_GRAB_FRESH;
              state_next = S_LINK;
            end else begin
              status_next = ST_FULL;
            end
          end
          CMD_DELETE: begin
            if (sts.count_zero) begin
              status_next = ST_EMPTY;
            end else if (sts.pos_zero || sts.pos_over) begin
              status_next = ST_BOUNDS;
            end else if (sts.pos_one && sts.count_one) begin
              ctl.op     = OP_DEL_ONLY;
              state_next = S_DROP;
            end else if (sts.pos_one) begin
              ctl.op     = OP_DEL_HEAD_READ;
              state_next = S_DEL_HEAD;
            end else begin
              ctl.op     = OP_WALK_START;
              state_next = S_WALK;
            end
          end
          default: begin
          end
        endcase
      end
      S_GRAB_FREE: begin
        ctl.op     = OP_GRAB_FREE;
        state_next = S_LINK;
      end
      S_LINK: begin
        if (sts.count_zero) begin
          ctl.op     = OP_LINK_ONLY;
          state_next = S_FIN;
        end else begin
          ctl.op     = OP_LINK_NEW;
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        ctl.op     = OP_LINK_TAIL;
        state_next = S_FIN;
      end
      S_DEL_HEAD: begin
        ctl.op     = OP_DEL_HEAD;
        state_next = S_DROP;
      end
      S_WALK: begin
        if (sts.walk_more) begin
          ctl.op = OP_WALK_STEP;
        end else begin
          ctl.op     = OP_WALK_END;
          state_next = S_UNLINK;
        end
      end
      S_UNLINK: begin
        ctl.op     = OP_UNLINK;
        state_next = S_DROP;
      end
      S_DROP: begin
        ctl.op     = OP_DROP;
        state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (load) begin
          ctl.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state, status and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      status_r  <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      status_r <= status_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/circular_list_manager_top.sv */
// Every item passes S_IDLE, S_DISPATCH, S_FIN and S_OUT; an error or an unused code adds
// no state. An insert adds S_GRAB_FREE when reusing a released entry, S_LINK, and S_TAIL
// for a non-empty list; a delete adds S_DEL_HEAD (position 1 of a longer list) or S_WALK
// and S_UNLINK (later positions), then S_DROP. No new item is taken before its result is
// loaded; a walk reads one link per cycle through the link store's single read port.
// Reset (rst, synchronous) empties the list and free list; the stores keep their contents.
module circular_list_manager_top import clm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // cmd[1:0], value[33:2], position[49:34], zero[55:50]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // status[1:0], length[10:2], first_value[42:11],
                                 // last_value[74:43], zero[79:75]
);

  dp_ctl_t                  ctl;
  dp_sts_t                  sts;
  logic [ST_W-1:0]          status;
  logic [LEN_W-1:0]         length;
  logic signed [DATA_W-1:0] first_value;
  logic signed [DATA_W-1:0] last_value;

  clm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .ctl       (ctl)
  );

  clm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .in_cmd      (s_tdata[1:0]),
    .in_value    (s_tdata[33:2]),
    .in_position (s_tdata[49:34]),
    .status      (status),
    .length      (length),
    .first_value (first_value),
    .last_value  (last_value)
  );

  // Pack the result item
  assign m_tdata = {5'b0, last_value, first_value, length, status};

`ifndef SYNTHESIS
  // One item in flight: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while another is in flight");

  // A full store reports a full list
  a_full_length: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_FULL) |-> (length == LEN_W'(CAPACITY)))
    else $error("store full reported with short list");

  // An empty list reports zero length and zero values
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status == ST_EMPTY) |-> (length == '0 && first_value == '0 &&
                                          last_value == '0))
    else $error("empty status with non-empty result");

  // Length never exceeds the store
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (32'(length) <= 32'(CAPACITY)))
    else $error("length beyond capacity");
`endif

endmodule

/* test/clm_list_checker.sv */
// Checker for the circular list manager: predicts each list report and compares it.
// Watches both stream channels of the block; depends on clm_pkg for widths and codes.
`timescale 1ns / 100ps

module clm_list_checker import clm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // cmd[1:0], value[33:2], position[49:34], zero[55:50]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [79:0] m_tdata,   // status[1:0], length[10:2], first_value[42:11],
                                 // last_value[74:43], zero[79:75]
  output int          fail_count,
  output int          outstanding,
  output int          reports_checked
);

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] back_value;
  } list_report_t;

  // Shadow copy of the list and its free list
  logic [DATA_W-1:0] list_vals  [CAPACITY];
  logic [IDX_W-1:0]  list_links [CAPACITY];
  logic [IDX_W-1:0]  front_idx;
  logic [IDX_W-1:0]  back_idx;
  logic [CNT_W-1:0]  entry_total;
  logic [IDX_W-1:0]  free_top;
  logic [CNT_W-1:0]  free_total;
  logic [CNT_W-1:0]  unused_next;

  list_report_t expected_reports [$];
  int mismatches = 0;
  int waiting    = 0;
  int checked    = 0;

  assign fail_count      = mismatches;
  assign outstanding     = waiting;
  assign reports_checked = checked;

  // Apply one command to the shadow list and report the list afterwards
  function automatic list_report_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [DATA_W-1:0] value,
                                                      input logic [POS_W-1:0] pos);
    list_report_t     rep;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] prev;
    logic [IDX_W-1:0] victim;
    logic             have_slot;
    int               i;
    rep.status = ST_OK;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        // Released entries first, then never-used ones
        have_slot = 1'b1;
        slot = '0;
        if (free_total != 0) begin
          slot = free_top;
          free_top = list_links[slot];
          free_total = free_total - 1'b1;
        end else if (unused_next < CAPACITY) begin
          slot = unused_next[IDX_W-1:0];
          unused_next = unused_next + 1'b1;
        end else begin
          have_slot = 1'b0;
        end
        if (!have_slot) begin
          rep.status = ST_FULL;
        end else begin
          list_vals[slot] = value;
          if (entry_total == 0) begin
            list_links[slot] = slot;
            front_idx = slot;
            back_idx = slot;
          end else begin
            list_links[slot] = front_idx;
            list_links[back_idx] = slot;
            if (cmd == CMD_INS_BACK) back_idx = slot;
            else front_idx = slot;
          end
          entry_total = entry_total + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (entry_total == 0) begin
          rep.status = ST_EMPTY;
        end else if (pos == 0 || pos > entry_total) begin
          rep.status = ST_BOUNDS;
        end else begin
          if (pos == 1) begin
            victim = front_idx;
            if (entry_total == 1) begin
              front_idx = '0;
              back_idx = '0;
            end else begin
              front_idx = list_links[victim];
              list_links[back_idx] = front_idx;
            end
          end else begin
            // Walk to the entry ahead of the one removed
            prev = front_idx;
            for (i = 2; i < pos; i++) prev = list_links[prev];
            victim = list_links[prev];
            list_links[prev] = list_links[victim];
            if (victim == back_idx) back_idx = prev;
          end
          entry_total = entry_total - 1'b1;
          list_links[victim] = free_top;
          free_top = victim;
          free_total = free_total + 1'b1;
        end
      end
      default: ;
    endcase
    rep.length = LEN_W'(entry_total);
    if (entry_total == 0) begin
      rep.front_value = '0;
      rep.back_value = '0;
    end else begin
      rep.front_value = list_vals[front_idx];
      rep.back_value = list_vals[back_idx];
    end
    return rep;
  endfunction

  task automatic compare_field(input string field, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Check results against the oldest expectation, then predict newly accepted items
  always @(posedge clk) begin
    list_report_t want;
    list_report_t got;
    if (rst) begin
      front_idx = '0;
      back_idx = '0;
      entry_total = '0;
      free_top = '0;
      free_total = '0;
      unused_next = '0;
      expected_reports.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata[1:0], m_tdata[10:2], m_tdata[42:11], m_tdata[74:43]};
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t ns: list report with no command outstanding, got %0h", $time, got);
        end else begin
          want = expected_reports.pop_front();
          compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
          compare_field("length", DATA_W'(want.length), DATA_W'(got.length));
          compare_field("first value", want.front_value, got.front_value);
          compare_field("last value", want.back_value, got.back_value);
          checked++;
        end
      end
      if (s_tvalid && s_tready)
        expected_reports.push_back(apply_list_command(s_tdata[1:0], s_tdata[33:2],
                                                      s_tdata[49:34]));
    end
    waiting = expected_reports.size();
  end

endmodule

/* test/tb_circular_list_manager_top.sv */
// Testbench top for the circular list manager: drives commands, stalls the result side.
// Depends on clm_pkg, circular_list_manager_top and the clm_list_checker module.
`timescale 1ns / 100ps

module tb_circular_list_manager_top import clm_pkg::*;;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_TARGET  = 1050;
  localparam int DRAIN_CYCLES = CAPACITY + 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // cmd[1:0], value[33:2], position[49:34], zero[55:50]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;        // status[1:0], length[10:2], first_value[42:11],
                               // last_value[74:43], zero[79:75]

  int fail_count;
  int outstanding;
  int reports_checked;

  // Stimulus bookkeeping
  int shadow_len    = 0;
  int peak_len      = 0;
  int items_sent    = 0;
  int inserts_sent  = 0;
  int full_refusals = 0;
  int deletes_sent  = 0;
  int unused_sent   = 0;
  logic steady_source = 1'b0;
  logic steady_sink   = 1'b0;
  int   sink_stall    = 0;

  always #6 clk = ~clk;

  circular_list_manager_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  clm_list_checker list_checker (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .reports_checked (reports_checked)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Stall the result side at random, except in steady stretches
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall <= 0;
    end else if (sink_stall != 0) begin
      m_tready <= 1'b0;
      sink_stall <= sink_stall - 1;
    end else begin
      m_tready <= 1'b1;
      if (!steady_sink && $urandom_range(0, 3) == 0) sink_stall <= pick_gap();
    end
  end

  // Offer one item, hold it until taken, then idle for a random gap except in steady stretches
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
                              input logic [POS_W-1:0] pos);
    int gap;
    if (items_sent % 40 == 0) begin
      steady_source <= ($urandom_range(0, 3) == 0);
      steady_sink <= ($urandom_range(0, 3) == 0);
    end
    s_tdata <= {6'd0, pos, value, cmd};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        inserts_sent++;
        if (shadow_len < CAPACITY) shadow_len++;
        else full_refusals++;
      end
      CMD_DELETE: begin
        deletes_sent++;
        if (shadow_len != 0 && pos != 0 && pos <= shadow_len) shadow_len--;
      end
      default: unused_sent++;
    endcase
    if (shadow_len > peak_len) peak_len = shadow_len;
    gap = steady_source ? 0 : pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Pick an insert, a valid delete or noise (bad positions, unused code) by weight
  task automatic send_shaped_command(input int insert_pct, input int delete_pct);
    int                roll;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    roll = $urandom_range(0, 99);
    value = pick_value();
    pos = POS_W'($urandom);
    if (roll < insert_pct) begin
      send_command($urandom_range(0, 1) ? CMD_INS_BACK : CMD_INS_FRONT, value, pos);
    end else if (roll < insert_pct + delete_pct && shadow_len != 0) begin
      case ($urandom_range(0, 4))
        0: pos = POS_W'(1);
        1: pos = POS_W'(shadow_len);
        default: pos = POS_W'($urandom_range(1, shadow_len));
      endcase
      send_command(CMD_DELETE, value, pos);
    end else if ($urandom_range(0, 2) == 0) begin
      send_command(CMD_UNUSED, value, pos);
    end else begin
      case ($urandom_range(0, 4))
        0: pos = '0;
        1: pos = POS_W'(shadow_len + 1);
        2: pos = POS_W'($urandom_range(shadow_len + 1, 16'hFFFF));
        3: pos = 16'hFFFF;
        default: ;
      endcase
      send_command(CMD_DELETE, value, pos);
    end
  endtask

  initial begin
    int ins_pct;
    int del_pct;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Empty list: deletes at any position, unused code
    send_command(CMD_DELETE, 32'h0, 16'd1);
    send_command(CMD_DELETE, 32'hFFFF_FFFF, 16'd0);
    send_command(CMD_DELETE, 32'h0, 16'hFFFF);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    // Build a short list from both ends with extreme values
    send_command(CMD_INS_FRONT, 32'h8000_0000, 16'hFFFF);
    send_command(CMD_INS_BACK, 32'h7FFF_FFFF, 16'h0);
    send_command(CMD_INS_FRONT, 32'hFFFF_FFFF, 16'h8000);
    send_command(CMD_INS_BACK, 32'h0, 16'h7FFF);
    send_command(CMD_INS_BACK, 32'h5A5A_A5A5, 16'h1234);
    send_command(CMD_UNUSED, 32'h1357_9BDF, 16'd2);
    // Out-of-bounds positions: zero, one past the end, largest
    send_command(CMD_DELETE, 32'h0, 16'd0);
    send_command(CMD_DELETE, 32'h0, 16'd6);
    send_command(CMD_DELETE, 32'h0, 16'hFFFF);
    // Remove last, middle and head, then reuse released entries
    send_command(CMD_DELETE, 32'h0, 16'd5);
    send_command(CMD_DELETE, 32'h0, 16'd2);
    send_command(CMD_DELETE, 32'h0, 16'd1);
    send_command(CMD_INS_FRONT, 32'h1234_5678, 16'h0);
    send_command(CMD_INS_BACK, 32'hDEAD_BEEF, 16'h0);
    send_command(CMD_DELETE, 32'h0, 16'd4);
    // Drain to empty, then refill a single entry from the free list
    send_command(CMD_DELETE, 32'h0, 16'd1);
    send_command(CMD_DELETE, 32'h0, 16'd1);
    send_command(CMD_DELETE, 32'h0, 16'd1);
    send_command(CMD_INS_BACK, 32'h0000_0001, 16'hFFFF);

    // Grow until the store is full and a few inserts are refused
    while (shadow_len < CAPACITY || full_refusals < 4) send_shaped_command(85, 10);
    // Shrink back almost to empty, reusing the free list afterwards
    while (shadow_len > 2) send_shaped_command(10, 80);
    // Mixed stretches with varying bias
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0: begin ins_pct = 70; del_pct = 20; end
        1: begin ins_pct = 20; del_pct = 70; end
        default: begin ins_pct = 45; del_pct = 45; end
      endcase
      repeat (30) send_shaped_command(ins_pct, del_pct);
    end
    s_tvalid <= 1'b0;

    // Let the checker log the last item, wait for every report, then allow for one more walk
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d commands: %0d inserts (%0d refused as full), %0d deletes, %0d unused.",
             items_sent, inserts_sent, full_refusals, deletes_sent, unused_sent);
    $display("Peak list length %0d; %0d reports checked, %0d mismatches.",
             peak_len, reports_checked, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("circular_list_manager_top test passed");
    end else begin
      $display("circular_list_manager_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #25_000_000;
    $display("circular_list_manager_top test failed");
    $finish;
  end

endmodule

/* files.f */
rtl/clm_pkg.sv
rtl/clm_datapath.sv
rtl/clm_controller.sv
rtl/circular_list_manager_top.sv
test/clm_list_checker.sv
test/tb_circular_list_manager_top.sv
